// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// Types and constants of the clock offset tracker.
// ----------------------------------------------------------------------------
package cet_pkg;

    localparam int TIME_W    = 64;
    localparam int STEP_W    = 63;
    localparam int CNT8_W    = 8;
    localparam int TMO_W     = 32;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 64;
    localparam int EMA_SHIFT = 3;

    localparam logic [STEP_W-1:0] MAX_STEP_RST  = STEP_W'(5000);
    localparam logic [CNT8_W-1:0] BOOTSTRAP_RST = CNT8_W'(8);
    localparam logic [CNT8_W-1:0] REJ_LIMIT_RST = CNT8_W'(5);
    localparam logic [TMO_W-1:0]  STALE_TMO_RST = '0;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BOOTSTRAP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_REJ_LIMIT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TMO = CFG_IDX_W'(3);

    typedef enum logic {
        OP_SYNC = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef struct packed {
        logic [STEP_W-1:0] max_step;
        logic [CNT8_W-1:0] bootstrap_count;
        logic [CNT8_W-1:0] reject_limit;
        logic [TMO_W-1:0]  stale_timeout;
    } t_cfg;

    // registered input item, raw offset already formed
    typedef struct packed {
        t_op                operation;
        logic [TIME_W-1:0]  raw_offset;
        logic [TIME_W-1:0]  local_time;
    } t_item;

    typedef struct packed {
        logic                       offset_valid;
        logic signed [TIME_W-1:0]   offset_estimate;
        logic                       sample_accepted;
        logic                       sample_rejected;
        logic                       reanchored;
        logic                       rejected_sticky;
        logic [COUNT_W-1:0]         samples_received;
        logic [COUNT_W-1:0]         samples_rejected;
    } t_result;

endpackage

// File: hw/rtl/cet_in_if.sv
// ----------------------------------------------------------------------------
// cet_in_if
// Input item channel: sync samples and staleness ticks.
// ----------------------------------------------------------------------------
interface cet_in_if import cet_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [TIME_W-1:0] remote_time;
    logic [TIME_W-1:0] local_time;

    modport source (output valid, operation, remote_time, local_time, input ready);
    modport sink   (input valid, operation, remote_time, local_time, output ready);
endinterface

// File: hw/rtl/cet_out_if.sv
// ----------------------------------------------------------------------------
// cet_out_if
// Result channel: one result word per input word.
// ----------------------------------------------------------------------------
interface cet_out_if import cet_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     offset_valid;
    logic signed [TIME_W-1:0] offset_estimate;
    logic                     sample_accepted;
    logic                     sample_rejected;
    logic                     reanchored;
    logic                     rejected_sticky;
    logic [COUNT_W-1:0]       samples_received;
    logic [COUNT_W-1:0]       samples_rejected;

    modport source (output valid, offset_valid, offset_estimate, sample_accepted,
                    sample_rejected, reanchored, rejected_sticky, samples_received,
                    samples_rejected, input ready);
    modport sink   (input valid, offset_valid, offset_estimate, sample_accepted,
                    sample_rejected, reanchored, rejected_sticky, samples_received,
                    samples_rejected, output ready);
endinterface

// File: hw/rtl/cet_cfg_if.sv
// ----------------------------------------------------------------------------
// cet_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface cet_cfg_if import cet_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/cet_cfg_regs.sv
// ----------------------------------------------------------------------------
// cet_cfg_regs
// Configuration registers, written through the register channel.
// ----------------------------------------------------------------------------
module cet_cfg_regs import cet_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_DAT_W-1:0] i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                REG_MAX_STEP:  n_cfg.max_step        = i_data[STEP_W-1:0];
                REG_BOOTSTRAP: n_cfg.bootstrap_count = i_data[CNT8_W-1:0];
                REG_REJ_LIMIT: n_cfg.reject_limit    = i_data[CNT8_W-1:0];
                REG_STALE_TMO: n_cfg.stale_timeout   = i_data[TMO_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_step        <= MAX_STEP_RST;
            r_cfg.bootstrap_count <= BOOTSTRAP_RST;
            r_cfg.reject_limit    <= REJ_LIMIT_RST;
            r_cfg.stale_timeout   <= STALE_TMO_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/cet_filter.sv
// ----------------------------------------------------------------------------
// cet_filter
// Tracker state, step gate and average update, one item per cycle on i_fire.
// ----------------------------------------------------------------------------
module cet_filter import cet_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);
    `include "assert_macros.svh"

    logic               r_valid,   n_valid;
    logic [TIME_W-1:0]  r_est,     n_est;
    logic [CNT8_W-1:0]  r_boot,    n_boot;
    logic [CNT8_W-1:0]  r_run,     n_run;
    logic [TIME_W-1:0]  r_last,    n_last;
    logic               r_sticky,  n_sticky;
    logic [COUNT_W-1:0] r_rx_cnt,  n_rx_cnt;
    logic [COUNT_W-1:0] r_rej_cnt, n_rej_cnt;

    logic [TIME_W:0]    diff;
    logic               diff_neg;
    logic [TIME_W:0]    diff_abs;
    logic [TIME_W-1:0]  gap_abs;
    logic [TIME_W-1:0]  ema_step;
    logic [TIME_W-1:0]  ema_est;
    logic               gate_fail;
    logic [CNT8_W-1:0]  run_inc;
    logic [TIME_W-1:0]  age;
    logic               stale;
    logic               accepted, rejected, reanch, do_update;
    logic [CNT8_W-1:0]  boot_base;

    // exact signed distance between raw offset and estimate
    always_comb begin
        diff      = {i_item.raw_offset[TIME_W-1], i_item.raw_offset}
                  - {r_est[TIME_W-1], r_est};
        diff_neg  = diff[TIME_W];
        diff_abs  = diff_neg ? (~diff + (TIME_W+1)'(1)) : diff;
        gap_abs   = diff_abs[TIME_W-1:0];
        gate_fail = gap_abs > {1'b0, i_cfg.max_step};
        // magnitude shift, i.e. truncation toward zero
        ema_step  = gap_abs >> EMA_SHIFT;
        ema_est   = diff_neg ? (r_est - ema_step) : (r_est + ema_step);
        run_inc   = r_run + CNT8_W'(1);
        age       = i_item.local_time - r_last;
        stale     = r_valid && (i_cfg.stale_timeout != '0)
                 && (i_item.local_time > r_last)
                 && (age > {{(TIME_W-TMO_W){1'b0}}, i_cfg.stale_timeout});
    end

    always_comb begin
        n_valid   = r_valid;
        n_est     = r_est;
        n_boot    = r_boot;
        n_run     = r_run;
        n_last    = r_last;
        n_sticky  = r_sticky;
        n_rx_cnt  = r_rx_cnt;
        n_rej_cnt = r_rej_cnt;
        accepted  = 1'b0;
        rejected  = 1'b0;
        reanch    = 1'b0;
        do_update = 1'b0;
        boot_base = r_boot;
        if (i_fire) begin
            case (i_item.operation)
                OP_SYNC: begin
                    n_rx_cnt  = r_rx_cnt + COUNT_W'(1);
                    do_update = 1'b1;
                    if (r_valid && (r_boot == '0) && gate_fail) begin
                        rejected  = 1'b1;
                        n_sticky  = 1'b1;
                        n_rej_cnt = r_rej_cnt + COUNT_W'(1);
                        if (run_inc < i_cfg.reject_limit) begin
                            do_update = 1'b0;
                            n_run     = run_inc;
                        end else begin
                            reanch    = 1'b1;
                            boot_base = i_cfg.bootstrap_count;
                        end
                    end
                    if (do_update) begin
                        accepted = 1'b1;
                        n_est    = (!r_valid || reanch) ? i_item.raw_offset : ema_est;
                        n_valid  = 1'b1;
                        n_last   = i_item.local_time;
                        n_run    = '0;
                        n_boot   = (boot_base != '0) ? boot_base - CNT8_W'(1) : '0;
                    end
                end
                OP_TICK: begin
                    if (stale) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_est     <= '0;
            r_boot    <= BOOTSTRAP_RST;
            r_run     <= '0;
            r_last    <= '0;
            r_sticky  <= 1'b0;
            r_rx_cnt  <= '0;
            r_rej_cnt <= '0;
        end else begin
            r_valid   <= n_valid;
            r_est     <= n_est;
            r_boot    <= n_boot;
            r_run     <= n_run;
            r_last    <= n_last;
            r_sticky  <= n_sticky;
            r_rx_cnt  <= n_rx_cnt;
            r_rej_cnt <= n_rej_cnt;
        end
    end

    always_comb begin
        o_result.offset_valid     = n_valid;
        o_result.offset_estimate  = n_est;
        o_result.sample_accepted  = accepted;
        o_result.sample_rejected  = rejected;
        o_result.reanchored       = reanch;
        o_result.rejected_sticky  = n_sticky;
        o_result.samples_received = n_rx_cnt;
        o_result.samples_rejected = n_rej_cnt;
    end

    `ASSERT_NEXT(a_reject_holds_est, i_clk, i_rst_n,
                 i_fire && rejected && !reanch, $stable(r_est),
                 "estimate moved on a plain rejection")
    `ASSERT_IMPL(a_no_gate_in_boot, i_clk, i_rst_n,
                 i_fire && (r_boot != '0), !rejected,
                 "sample gated during bootstrap")
    `ASSERT_NEXT(a_tick_keeps_count, i_clk, i_rst_n,
                 i_fire && (i_item.operation == OP_TICK),
                 $stable(r_rx_cnt) && $stable(r_est),
                 "tick changed sample state")

endmodule

// File: hw/rtl/clock_offset_ema_tracker_unit.sv
// ----------------------------------------------------------------------------
// clock_offset_ema_tracker_unit
// Gated moving-average estimate of the offset between a remote and a local
// clock, with step gate, re-anchor after repeated rejections and staleness.
//
//   channel   dir   handshake      contents
//   i_in      in    valid/ready    operation, remote_time, local_time
//   o_out     out   valid/ready    estimate, flags and counters
//   i_cfg     in    valid/ready    register index and write data
//
// one word per cycle sustained unless the result register stalls
// input register holds the raw offset; the gate and average update run
// combinationally between it and the result register, with the state write
// a stalled result register stops the input register, which then stops the input
// reset is synchronous and brings valid, state and config registers back to their default values
// register writes are always ready out of reset
// ----------------------------------------------------------------------------
module clock_offset_ema_tracker_unit import cet_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cet_in_if.sink    i_in,
    cet_out_if.source o_out,
    cet_cfg_if.sink   i_cfg
);
    `include "assert_macros.svh"

    t_cfg    cfg;
    t_result result;
    logic    adv;
    logic    cfg_wr;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;

    assign i_cfg.ready = i_rst_n;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    cet_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || adv);

    // input register, raw offset formed on entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.operation  <= t_op'(i_in.operation);
            r_item.raw_offset <= i_in.local_time - i_in.remote_time;
            r_item.local_time <= i_in.local_time;
        end
    end

    cet_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (adv),
        .i_item   (r_item),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.offset_valid     = r_out.offset_valid;
    assign o_out.offset_estimate  = r_out.offset_estimate;
    assign o_out.sample_accepted  = r_out.sample_accepted;
    assign o_out.sample_rejected  = r_out.sample_rejected;
    assign o_out.reanchored       = r_out.reanchored;
    assign o_out.rejected_sticky  = r_out.rejected_sticky;
    assign o_out.samples_received = r_out.samples_received;
    assign o_out.samples_rejected = r_out.samples_rejected;

    `ASSERT_NEXT(a_in_kept, i_clk, i_rst_n,
                 r_in_valid && !adv, r_in_valid && $stable(r_item),
                 "held word lost")
    `ASSERT_NEXT(a_adv_loads_out, i_clk, i_rst_n,
                 adv, r_out_valid,
                 "result not registered")
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n,
                 !r_in_valid, i_in.ready,
                 "empty input register not ready")

endmodule
